/* rtl/rtc2ep_pkg.sv */
// ----------------------------------------------------------------------------
// rtc2ep_pkg
// Shared types, constants and helper functions for the BCD clock snapshot to
// epoch seconds converter.
// ----------------------------------------------------------------------------
package rtc2ep_pkg;

  localparam int unsigned YearW  = 13;
  localparam int unsigned DaysW  = 20;
  localparam int unsigned HmsW   = 18;
  localparam int unsigned ProdW  = 37;
  localparam int unsigned SumW   = 38;
  localparam int unsigned OutW   = 33;
  localparam int unsigned CentW  = 12;
  localparam int unsigned Q25W   = 9;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [YearW-1:0] YEAR_COUNT_START = 13'd1970;
  localparam logic [1:0]       EPOCH_MOD4     = 2'd2;
  localparam logic [6:0]       EPOCH_MOD100   = 7'd70;
  localparam logic [8:0]       EPOCH_MOD400   = 9'd370;
  localparam logic [6:0]       LAST_MOD100    = 7'd99;
  localparam logic [8:0]       LAST_MOD400    = 9'd399;
  localparam logic [CentW-1:0] CENTURY_RESET  = 12'd2000;
  localparam logic [16:0]      SECS_PER_DAY   = 17'd86400;
  localparam logic [12:0]      RECIP25        = 13'd5243;
  localparam int unsigned      RECIP25_SHIFT  = 17;
  localparam logic [3:0]       MAX_WHOLE_MON  = 4'd11;
  localparam logic [3:0]       FEB_INDEX      = 4'd1;

  // register index decoded from paddr
  localparam logic REG_CENTURY = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_YEARS,
    ST_LEAP,
    ST_MONTHS,
    ST_MUL,
    ST_SUM
  } rtc2ep_state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic year_step;
    logic leap;
    logic month_step;
    logic mul;
    logic sum;
  } rtc2ep_cmd_t;

  typedef struct packed {
    logic year_more;
    logic month_more;
    logic out_full;
  } rtc2ep_sts_t;

  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'd0, b[7:4]};
    return (tens << 3) + (tens << 1) + {4'd0, b[3:0]};
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    unique case (m)
      4'd1:    d = 5'd28;
      4'd3:    d = 5'd30;
      4'd5:    d = 5'd30;
      4'd8:    d = 5'd30;
      4'd10:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

/* rtl/bcd_rtc_to_epoch_seconds.sv */
// work: after a transfer in, prep, then the whole years from 1970 are counted
// (one per cycle), then the leap test, then the whole months of the current
// year (one per cycle), then multiply and sum; the sum waits while a pending
// result is stalled. No new snapshot is taken until the controller is idle.
// reset: asynchronous active low, controller idle, no result pending,
// century base 2000
// ----------------------------------------------------------------------------
// bcd_rtc_to_epoch_seconds
// Converts one BCD real-time-clock snapshot into seconds since 1970-01-01.
// ----------------------------------------------------------------------------
module bcd_rtc_to_epoch_seconds
  import rtc2ep_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [6:0]       second_bcd_i,
  input  logic [6:0]       minute_bcd_i,
  input  logic [5:0]       hour_bcd_i,
  input  logic [5:0]       day_bcd_i,
  input  logic [4:0]       month_bcd_i,
  input  logic [7:0]       year_bcd_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [OutW-1:0]  epoch_seconds_o
);

  logic [CentW-1:0] century_q;
  logic             cfg_wr;
  rtc2ep_cmd_t      cmd;
  rtc2ep_sts_t      sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CENTURY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      century_q <= CENTURY_RESET;
    end else if (cfg_wr) begin
      century_q <= pwdata[CentW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CENTURY) ? DataW'(century_q) : '0;

  rtc2ep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rtc2ep_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .century_i       (century_q),
    .second_bcd_i    (second_bcd_i),
    .minute_bcd_i    (minute_bcd_i),
    .hour_bcd_i      (hour_bcd_i),
    .day_bcd_i       (day_bcd_i),
    .month_bcd_i     (month_bcd_i),
    .year_bcd_i      (year_bcd_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .epoch_seconds_o (epoch_seconds_o)
  );

  // a transfer in starts work, so no second snapshot is taken next cycle
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous snapshot in work");

  // a new result only appears at the end of work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result produced without a snapshot in work");

  // the result register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(epoch_seconds_o)))
    else $error("pending result lost or changed");

endmodule

/* rtl/rtc2ep_dp.sv */
// ----------------------------------------------------------------------------
// rtc2ep_dp
// Datapath: BCD decode, year and month day counting, leap tests, day to
// seconds multiply, final sum with saturation and the result register.
// ----------------------------------------------------------------------------
module rtc2ep_dp
  import rtc2ep_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtc2ep_cmd_t       cmd_i,
  output rtc2ep_sts_t       sts_o,
  input  logic [CentW-1:0]  century_i,
  input  logic [6:0]        second_bcd_i,
  input  logic [6:0]        minute_bcd_i,
  input  logic [5:0]        hour_bcd_i,
  input  logic [5:0]        day_bcd_i,
  input  logic [4:0]        month_bcd_i,
  input  logic [7:0]        year_bcd_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [OutW-1:0]   epoch_seconds_o
);

  logic [6:0]       sec_q, min_q;
  logic [5:0]       hour_q;
  logic [YearW-1:0] year_q, y_q;
  logic [1:0]       mod4_q;
  logic [6:0]       mod100_q;
  logic [8:0]       mod400_q;
  logic [Q25W-1:0]  q25_q;
  logic             leap_q;
  logic [3:0]       mon_q, whole_q;
  logic [DaysW-1:0] days_q, days_d;
  logic [HmsW-1:0]  hms_q;
  logic [ProdW-1:0] prod_q;
  logic [OutW-1:0]  out_q;
  logic             out_valid_q, out_valid_d;

  logic [5:0]       day_dec;
  logic [4:0]       mon_dec;
  logic [3:0]       whole_d;
  logic             cnt_leap;
  logic [25:0]      recip_prod;
  logic [YearW-1:0] q25_times25;
  logic             cur_leap;
  logic [SumW-1:0]  total;
  logic [4:0]       mon_add;

  assign day_dec = 6'(bcd_decode({2'd0, day_bcd_i}));
  assign mon_dec = 5'(bcd_decode({3'd0, month_bcd_i}));

  always_comb begin
    if (mon_dec == 5'd0) begin
      whole_d = 4'd0;
    end else if ((mon_dec - 5'd1) > {1'b0, MAX_WHOLE_MON}) begin
      whole_d = MAX_WHOLE_MON;
    end else begin
      whole_d = 4'(mon_dec - 5'd1);
    end
  end

  // leap test of the year being counted, from running remainders
  assign cnt_leap = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));

  // current year: divisible by 25 via reciprocal multiply
  assign recip_prod  = 26'(year_q) * 26'(RECIP25);
  assign q25_times25 = 13'({4'd0, q25_q} << 4) + 13'({4'd0, q25_q} << 3) + 13'(q25_q);
  assign cur_leap    = (year_q[1:0] == 2'd0)
                     && ((q25_times25 != year_q) || (year_q[3:0] == 4'd0));

  assign mon_add = month_days(mon_q);

  always_comb begin
    days_d = days_q;
    if (cmd_i.load) begin
      days_d = (day_dec == 6'd0) ? '0 : DaysW'(day_dec - 6'd1);
    end else if (cmd_i.year_step) begin
      days_d = days_q + (cnt_leap ? DaysW'(366) : DaysW'(365));
    end else if (cmd_i.month_step) begin
      days_d = days_q + DaysW'(mon_add)
             + DaysW'((mon_q == FEB_INDEX) && leap_q);
    end
  end

  assign total = SumW'(prod_q) + SumW'(hms_q);

  always_ff @(posedge clk_i) begin
    days_q <= days_d;
    if (cmd_i.load) begin
      sec_q   <= 7'(bcd_decode({1'b0, second_bcd_i}));
      min_q   <= 7'(bcd_decode({1'b0, minute_bcd_i}));
      hour_q  <= 6'(bcd_decode({2'd0, hour_bcd_i}));
      year_q  <= YearW'(century_i) + YearW'(bcd_decode(year_bcd_i));
      whole_q <= whole_d;
      y_q      <= YEAR_COUNT_START;
      mod4_q   <= EPOCH_MOD4;
      mod100_q <= EPOCH_MOD100;
      mod400_q <= EPOCH_MOD400;
      mon_q    <= 4'd0;
    end
    if (cmd_i.prep) begin
      q25_q <= recip_prod[RECIP25_SHIFT +: Q25W];
      hms_q <= HmsW'(hour_q) * HmsW'(3600) + HmsW'(min_q) * HmsW'(60) + HmsW'(sec_q);
    end
    if (cmd_i.year_step) begin
      y_q      <= y_q + YearW'(1);
      mod4_q   <= mod4_q + 2'd1;
      mod100_q <= (mod100_q == LAST_MOD100) ? 7'd0 : mod100_q + 7'd1;
      mod400_q <= (mod400_q == LAST_MOD400) ? 9'd0 : mod400_q + 9'd1;
    end
    if (cmd_i.leap) begin
      leap_q <= cur_leap;
    end
    if (cmd_i.month_step) begin
      mon_q <= mon_q + 4'd1;
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(days_q) * ProdW'(SECS_PER_DAY);
    end
    if (cmd_i.sum) begin
      out_q <= (total[SumW-1:OutW] != '0) ? '1 : total[OutW-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.sum) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.year_more  = (y_q < year_q);
  assign sts_o.month_more = (mon_q < whole_q);
  assign sts_o.out_full   = out_valid_q && out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign epoch_seconds_o = out_q;

endmodule

/* rtl/rtc2ep_ctrl.sv */
// ----------------------------------------------------------------------------
// rtc2ep_ctrl
// Controller: sequences load, prep, year counting, leap test, month counting,
// multiply and final sum for one snapshot at a time.
// ----------------------------------------------------------------------------
module rtc2ep_ctrl
  import rtc2ep_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rtc2ep_sts_t sts_i,
  output rtc2ep_cmd_t cmd_o
);

  rtc2ep_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP:   state_d = ST_YEARS;
      ST_YEARS: begin
        if (!sts_i.year_more) state_d = ST_LEAP;
      end
      ST_LEAP:   state_d = ST_MONTHS;
      ST_MONTHS: begin
        if (!sts_i.month_more) state_d = ST_MUL;
      end
      ST_MUL:    state_d = ST_SUM;
      ST_SUM: begin
        if (!sts_i.out_full) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_PREP:   cmd_o.prep       = 1'b1;
      ST_YEARS:  cmd_o.year_step  = sts_i.year_more;
      ST_LEAP:   cmd_o.leap       = 1'b1;
      ST_MONTHS: cmd_o.month_step = sts_i.month_more;
      ST_MUL:    cmd_o.mul        = 1'b1;
      ST_SUM:    cmd_o.sum        = !sts_i.out_full;
      default:   cmd_o            = '0;
    endcase
  end

endmodule
